FILE: src/bhfso_pkg.sv
// Package for the printable-byte histogram with first-seen order.
// Holds sizes, request/result structs, command and state types, helpers.
// No dependencies.
package bhfso_pkg;

    localparam int COUNT_SLOTS = 256;
    localparam int ORDER_DEPTH = 128;
    localparam int COUNT_BITS  = 32;

    localparam int COUNT_AW = $clog2(COUNT_SLOTS);
    localparam int ORDER_AW = $clog2(ORDER_DEPTH);

    localparam logic [7:0] PRINT_LO     = 8'd32;
    localparam logic [7:0] PRINT_HI     = 8'd126;
    localparam logic [6:0] DISTINCT_MAX = 7'd127;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    typedef logic [COUNT_BITS-1:0] count_t;

    localparam count_t COUNT_ONE = count_t'(1);

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] char_in;
        logic [6:0] order_index;
    } request_t;

    typedef struct packed {
        logic [7:0]  char_out;
        logic [31:0] count_out;
        logic [6:0]  distinct_total;
        logic        entry_valid;
        logic        accepted;
    } result_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_READ,
        OP_CLEAR,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
        logic [6:0] idx;
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_RD_ORD,
        S_RD_CNT
    } state_t;

    function automatic logic [31:0] clamp_count(count_t v);
        logic [63:0] w;
        w = 64'(v);
        if (w > 64'h0000_0000_FFFF_FFFF)
            return 32'hFFFF_FFFF;
        return w[31:0];
    endfunction

    function automatic count_t sat_inc(count_t v);
        if (&v)
            return v;
        return v + COUNT_ONE;
    endfunction

endpackage

FILE: src/bhfso_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bhfso_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/bhfso_front.sv
// Front end: takes requests, classifies them into commands, holds them
// in a two-entry queue for the back end. Depends on bhfso_pkg.
module bhfso_front
    import bhfso_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  request_t request,
    input  logic     cmd_pop,
    output logic     cmd_empty,
    output cmd_t     cmd_head
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    cmd_t       cmd_in;
    logic       do_push;
    logic       do_pop;

    always_comb
    begin
        cmd_in.ch  = request.char_in;
        cmd_in.idx = request.order_index;
        case (request.func)
            FUNC_ADD:
            begin
                if (request.char_in inside {[PRINT_LO:PRINT_HI]})
                    cmd_in.op = OP_ADD;
                else
                    cmd_in.op = OP_NONE;
            end
            FUNC_READ:  cmd_in.op = OP_READ;
            FUNC_CLEAR: cmd_in.op = OP_CLEAR;
            default:    cmd_in.op = OP_NONE;
        endcase
    end

    assign full      = (fill_reg == 2'd2);
    assign cmd_empty = (fill_reg == 2'd0);
    assign cmd_head  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && !cmd_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

FILE: src/bhfso_back.sv
// Back end: executes commands against seen flags, count RAM and order RAM.
// Depends on bhfso_pkg and bhfso_ram.
module bhfso_back
    import bhfso_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_empty,
    input  cmd_t    cmd_head,
    output logic    cmd_pop,
    input  logic    res_full,
    output logic    res_push,
    output result_t res_data
);

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [7:0]             ch_reg, ch_next;
    logic [COUNT_SLOTS-1:0] seen_reg, seen_next;
    logic [6:0]             distinct_reg, distinct_next;

    logic                   cnt_we;
    logic [COUNT_AW-1:0]    cnt_waddr;
    count_t                 cnt_wdata;
    logic [COUNT_AW-1:0]    cnt_raddr;
    count_t                 cnt_rdata;
    logic                   ord_we;
    logic [ORDER_AW-1:0]    ord_waddr;
    logic [7:0]             ord_wdata;
    logic [ORDER_AW-1:0]    ord_raddr;
    logic [7:0]             ord_rdata;

    logic                   seen_hit;
    count_t                 cnt_new;
    logic                   can_append;

    bhfso_ram #(.WIDTH(COUNT_BITS), .DEPTH(COUNT_SLOTS)) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    bhfso_ram #(.WIDTH(8), .DEPTH(ORDER_DEPTH)) u_order_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    assign seen_hit   = seen_reg[COUNT_AW'(cmd_reg.ch)];
    assign cnt_new    = seen_hit ? sat_inc(cnt_rdata) : COUNT_ONE;
    assign can_append = (int'(distinct_reg) < ORDER_DEPTH) && (distinct_reg < DISTINCT_MAX);

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        ch_next       = ch_reg;
        seen_next     = seen_reg;
        distinct_next = distinct_reg;
        cmd_pop       = 1'b0;
        res_push      = 1'b0;
        res_data      = '0;
        cnt_we        = 1'b0;
        cnt_waddr     = COUNT_AW'(cmd_reg.ch);
        cnt_wdata     = cnt_new;
        cnt_raddr     = COUNT_AW'(cmd_head.ch);
        ord_we        = 1'b0;
        ord_waddr     = ORDER_AW'(distinct_reg);
        ord_wdata     = cmd_reg.ch;
        ord_raddr     = ORDER_AW'(cmd_head.idx);

        case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd_head;
                    case (cmd_head.op)
                        OP_ADD:
                        begin
                            state_next = S_ADD;
                        end
                        OP_READ:
                        begin
                            if (cmd_head.idx < distinct_reg)
                            begin
                                state_next = S_RD_ORD;
                            end
                            else
                            begin
                                res_push                = 1'b1;
                                res_data.distinct_total = distinct_reg;
                            end
                        end
                        OP_CLEAR:
                        begin
                            seen_next     = '0;
                            distinct_next = '0;
                            res_push      = 1'b1;
                        end
                        default:
                        begin
                            res_push                = 1'b1;
                            res_data.distinct_total = distinct_reg;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                cnt_we = 1'b1;
                seen_next[COUNT_AW'(cmd_reg.ch)] = 1'b1;
                if (!seen_hit && can_append)
                begin
                    ord_we        = 1'b1;
                    distinct_next = distinct_reg + 7'd1;
                end
                res_push                = 1'b1;
                res_data.count_out      = clamp_count(cnt_new);
                res_data.distinct_total = distinct_next;
                res_data.accepted       = 1'b1;
                state_next              = S_IDLE;
            end
            S_RD_ORD:
            begin
                cnt_raddr  = COUNT_AW'(ord_rdata);
                ch_next    = ord_rdata;
                state_next = S_RD_CNT;
            end
            S_RD_CNT:
            begin
                res_push                = 1'b1;
                res_data.char_out       = ch_reg;
                res_data.count_out      = clamp_count(cnt_rdata);
                res_data.distinct_total = distinct_reg;
                res_data.entry_valid    = 1'b1;
                state_next              = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            seen_reg     <= '0;
            distinct_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            seen_reg     <= seen_next;
            distinct_reg <= distinct_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        ch_reg  <= ch_next;
    end

endmodule

FILE: src/bhfso_outq.sv
// Two-entry result queue between the back end and the result port.
// Depends on bhfso_pkg.
module bhfso_outq
    import bhfso_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_push,
    input  result_t res_data,
    output logic    res_full,
    input  logic    pop,
    output logic    empty,
    output result_t result
);

    result_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push;
    logic       do_pop;

    assign res_full = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign result   = slot_reg[rd_ptr_reg];
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= res_data;
        end
    end

endmodule

FILE: src/byte_histogram_first_seen_order_top.sv
// Top level of the printable-byte histogram with first-seen order.
// Depends on bhfso_pkg, bhfso_front, bhfso_back, bhfso_outq.
//
// Usage:
//   Request side is a queue: a request (func, char_in, order_index) is taken
//   at a clock edge with push high and full low. Result side is a queue: the
//   oldest result sits on result while empty is low and leaves on an edge
//   with pop high and empty low. Every request yields exactly one result.
//   The back end handles one command at a time and takes the next only
//   once the last has pushed its result: add of a printable byte goes
//   through the add state, read of a valid entry through an order RAM read,
//   then a count RAM read; clear, invalid reads and ignored bytes are
//   answered from idle. A two-entry request queue and a two-entry result
//   queue decouple the sides; when the receiver stalls, the back end stops
//   once the result queue fills, then the request queue fills and full rises.
//   Reset clears seen flags, the distinct count and both queues at once;
//   requests are taken on the first cycle after reset. Count and order
//   RAM contents are not reset and are only used once written.
module byte_histogram_first_seen_order_top
    import bhfso_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  request_t request,
    output logic     empty,
    input  logic     pop,
    output result_t  result
);

    logic    cmd_pop;
    logic    cmd_empty;
    cmd_t    cmd_head;
    logic    res_full;
    logic    res_push;
    result_t res_data;

    bhfso_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .cmd_pop   (cmd_pop),
        .cmd_empty (cmd_empty),
        .cmd_head  (cmd_head)
    );

    bhfso_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    bhfso_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_data (res_data),
        .res_full (res_full),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule
